[src/assert_macros.svh]
// Assertion macros shared by the serializer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ldfs_pkg.sv]
// Package for the LED driver frame serializer: sizes, frame layout, codes, types.
// No dependencies; used by every module of the block except ldfs_ram.
package ldfs_pkg;

  localparam int NUM_LEDS     = 16;
  localparam int GRAY_WIDTH   = 16;
  localparam int CHANNELS     = 3 * NUM_LEDS;
  localparam int GRAY_BITS    = 1 + CHANNELS * GRAY_WIDTH;
  localparam int CTRL_ZEROS   = 389;
  localparam int CTRL_FUNC_AT = 9 + CTRL_ZEROS;
  localparam int CTRL_BC_AT   = CTRL_FUNC_AT + 5;
  localparam int CTRL_MC_AT   = CTRL_BC_AT + 21;
  localparam int CTRL_DC_AT   = CTRL_MC_AT + 9;
  localparam int CTRL_BITS    = CTRL_DC_AT + 7 * CHANNELS;

  localparam int POS_W     = 10;
  localparam int LED_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int GBIT_W    = $clog2(GRAY_WIDTH);
  localparam int ROW_W     = 3 * GRAY_WIDTH;
  localparam int ROW_IDX_W = $clog2(ROW_W);
  localparam int CFG_ADDR_W = 5;

  localparam logic [7:0] CTRL_KEY  = 8'h96;
  localparam logic [1:0] CHAN_RED  = 2'd0;
  localparam logic [1:0] CHAN_BLUE = 2'd2;

  typedef enum logic [1:0] {
    CMD_SET_COLOR = 2'd0,
    CMD_SEND_GRAY = 2'd1,
    CMD_SEND_CTRL = 2'd2,
    CMD_TICK      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_FUNC     = 3'd0,
    REG_BR_RED   = 3'd1,
    REG_BR_GREEN = 3'd2,
    REG_BR_BLUE  = 3'd3,
    REG_MC_RED   = 3'd4,
    REG_MC_GREEN = 3'd5,
    REG_MC_BLUE  = 3'd6,
    REG_DOT      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [4:0] function_bits;
    logic [6:0] bright_red;
    logic [6:0] bright_green;
    logic [6:0] bright_blue;
    logic [2:0] current_red;
    logic [2:0] current_green;
    logic [2:0] current_blue;
    logic [6:0] dot_correction;
  } cfg_t;

  typedef struct packed {
    cmd_t        command;
    logic [3:0]  led_index;
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;
  } in_item_t;

  typedef struct packed {
    logic              sd_fixed;
    logic              use_ram;
    logic              row_valid;
    logic [1:0]        chan;
    logic [GBIT_W-1:0] bit_sel;
    logic              shift_clock;
    logic              latch_pulse;
    logic              busy;
    logic              rejected;
  } stage_t;

  typedef struct packed {
    logic             we;
    logic [LED_W-1:0] waddr;
    logic [ROW_W-1:0] wdata;
    logic [LED_W-1:0] raddr;
  } ram_req_t;

endpackage

[src/ldfs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ldfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ldfs_cfg.sv]
// APB-style configuration registers of the serializer.
// Depends on ldfs_pkg for the register codes and the cfg_t layout.
module ldfs_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ldfs_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output ldfs_pkg::cfg_t                     cfg
);

  logic               wr;
  ldfs_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = ldfs_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.function_bits  <= 5'd25;
      cfg.bright_red     <= 7'h7F;
      cfg.bright_green   <= 7'h7F;
      cfg.bright_blue    <= 7'h7F;
      cfg.current_red    <= 3'd0;
      cfg.current_green  <= 3'd0;
      cfg.current_blue   <= 3'd0;
      cfg.dot_correction <= 7'h7F;
    end else if (wr) begin
      case (idx)
        ldfs_pkg::REG_FUNC:     cfg.function_bits  <= pwdata[4:0];
        ldfs_pkg::REG_BR_RED:   cfg.bright_red     <= pwdata[6:0];
        ldfs_pkg::REG_BR_GREEN: cfg.bright_green   <= pwdata[6:0];
        ldfs_pkg::REG_BR_BLUE:  cfg.bright_blue    <= pwdata[6:0];
        ldfs_pkg::REG_MC_RED:   cfg.current_red    <= pwdata[2:0];
        ldfs_pkg::REG_MC_GREEN: cfg.current_green  <= pwdata[2:0];
        ldfs_pkg::REG_MC_BLUE:  cfg.current_blue   <= pwdata[2:0];
        ldfs_pkg::REG_DOT:      cfg.dot_correction <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ldfs_pkg::REG_FUNC:     prdata = 32'(cfg.function_bits);
      ldfs_pkg::REG_BR_RED:   prdata = 32'(cfg.bright_red);
      ldfs_pkg::REG_BR_GREEN: prdata = 32'(cfg.bright_green);
      ldfs_pkg::REG_BR_BLUE:  prdata = 32'(cfg.bright_blue);
      ldfs_pkg::REG_MC_RED:   prdata = 32'(cfg.current_red);
      ldfs_pkg::REG_MC_GREEN: prdata = 32'(cfg.current_green);
      ldfs_pkg::REG_MC_BLUE:  prdata = 32'(cfg.current_blue);
      ldfs_pkg::REG_DOT:      prdata = 32'(cfg.dot_correction);
      default:                prdata = '0;
    endcase
  end

endmodule

[src/ldfs_ctrl.sv]
// Input register and frame sequencer: command decode, bit counter, control-frame bits,
// grayscale store addressing and row valid bits. Depends on ldfs_pkg.
module ldfs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_valid,
  input  ldfs_pkg::in_item_t  s_item,
  output logic                s_ready,
  input  ldfs_pkg::cfg_t      cfg,
  input  logic                advance,
  output logic                s2_valid,
  output ldfs_pkg::stage_t    s2,
  output ldfs_pkg::ram_req_t  ram
);

  localparam logic [ldfs_pkg::GBIT_W-1:0] GBIT_RST = ldfs_pkg::GBIT_W'(ldfs_pkg::GRAY_WIDTH - 1);
  localparam logic [ldfs_pkg::LED_W-1:0]  GLED_RST = ldfs_pkg::LED_W'(ldfs_pkg::NUM_LEDS - 1);
  localparam int PW = ldfs_pkg::POS_W;

  logic               s1_valid;
  ldfs_pkg::in_item_t s1;
  logic               fire;

  logic                       sending, sending_next;
  logic                       frame_kind, frame_kind_next;
  logic                       pass_count, pass_count_next;
  logic [PW-1:0]              bit_position, bit_position_next;
  logic [ldfs_pkg::GBIT_W-1:0] g_bit, g_bit_next;
  logic [1:0]                 g_chan, g_chan_next;
  logic [ldfs_pkg::LED_W-1:0] g_led, g_led_next;
  logic [2:0]                 dc_phase, dc_phase_next;
  logic [ldfs_pkg::NUM_LEDS-1:0] row_valid;

  logic [PW-1:0]  frame_len;
  logic [PW-1:0]  r_func, r_bc, r_mc;
  logic [20:0]    bc_vec;
  logic [8:0]     mc_vec;
  logic           ctrl_bit;
  logic           led_ok;
  ldfs_pkg::stage_t st;

  assign s_ready = !s1_valid || advance;
  assign fire    = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_ready) begin
      s1_valid <= s_valid;
    end
    if (s_ready && s_valid) begin
      s1 <= s_item;
    end
  end

  assign frame_len = frame_kind ? PW'(ldfs_pkg::CTRL_BITS) : PW'(ldfs_pkg::GRAY_BITS);
  assign r_func    = bit_position - PW'(ldfs_pkg::CTRL_FUNC_AT);
  assign r_bc      = bit_position - PW'(ldfs_pkg::CTRL_BC_AT);
  assign r_mc      = bit_position - PW'(ldfs_pkg::CTRL_MC_AT);
  assign bc_vec    = {cfg.bright_blue, cfg.bright_green, cfg.bright_red};
  assign mc_vec    = {cfg.current_blue, cfg.current_green, cfg.current_red};
  assign led_ok    = {1'b0, s1.led_index} < 5'(ldfs_pkg::NUM_LEDS);

  always_comb begin
    if (bit_position == '0) begin
      ctrl_bit = 1'b1;
    end else if (bit_position < PW'(9)) begin
      ctrl_bit = ldfs_pkg::CTRL_KEY[3'(PW'(8) - bit_position)];
    end else if (bit_position < PW'(ldfs_pkg::CTRL_FUNC_AT)) begin
      ctrl_bit = 1'b0;
    end else if (bit_position < PW'(ldfs_pkg::CTRL_BC_AT)) begin
      ctrl_bit = cfg.function_bits[3'(PW'(4) - r_func)];
    end else if (bit_position < PW'(ldfs_pkg::CTRL_MC_AT)) begin
      ctrl_bit = bc_vec[5'(PW'(20) - r_bc)];
    end else if (bit_position < PW'(ldfs_pkg::CTRL_DC_AT)) begin
      ctrl_bit = mc_vec[4'(PW'(8) - r_mc)];
    end else begin
      ctrl_bit = cfg.dot_correction[dc_phase];
    end
  end

  always_comb begin
    sending_next      = sending;
    frame_kind_next   = frame_kind;
    pass_count_next   = pass_count;
    bit_position_next = bit_position;
    g_bit_next        = g_bit;
    g_chan_next       = g_chan;
    g_led_next        = g_led;
    dc_phase_next     = dc_phase;

    st.sd_fixed    = 1'b0;
    st.use_ram     = 1'b0;
    st.row_valid   = row_valid[g_led];
    st.chan        = g_chan;
    st.bit_sel     = g_bit;
    st.shift_clock = 1'b0;
    st.latch_pulse = 1'b0;
    st.rejected    = 1'b0;

    ram.we    = 1'b0;
    ram.waddr = s1.led_index[ldfs_pkg::LED_W-1:0];
    ram.wdata = {s1.blue_level[ldfs_pkg::GRAY_WIDTH-1:0],
                 s1.green_level[ldfs_pkg::GRAY_WIDTH-1:0],
                 s1.red_level[ldfs_pkg::GRAY_WIDTH-1:0]};
    ram.raddr = g_led;

    if (s1.command != ldfs_pkg::CMD_TICK && sending) begin
      st.rejected = 1'b1;
    end else begin
      case (s1.command)
        ldfs_pkg::CMD_SET_COLOR: begin
          ram.we = fire && led_ok;
        end
        ldfs_pkg::CMD_SEND_GRAY, ldfs_pkg::CMD_SEND_CTRL: begin
          sending_next      = 1'b1;
          frame_kind_next   = (s1.command == ldfs_pkg::CMD_SEND_CTRL);
          pass_count_next   = 1'b0;
          bit_position_next = '0;
          g_bit_next        = GBIT_RST;
          g_chan_next       = ldfs_pkg::CHAN_BLUE;
          g_led_next        = GLED_RST;
          dc_phase_next     = 3'd6;
        end
        ldfs_pkg::CMD_TICK: begin
          if (sending) begin
            if (bit_position < frame_len) begin
              st.shift_clock    = 1'b1;
              bit_position_next = bit_position + 1'b1;
              if (frame_kind) begin
                st.sd_fixed = ctrl_bit;
                if (bit_position >= PW'(ldfs_pkg::CTRL_DC_AT)) begin
                  dc_phase_next = (dc_phase == 3'd0) ? 3'd6 : dc_phase - 3'd1;
                end
              end else if (bit_position != '0) begin
                st.use_ram = 1'b1;
                if (g_bit == '0) begin
                  g_bit_next = GBIT_RST;
                  if (g_chan == ldfs_pkg::CHAN_RED) begin
                    g_chan_next = ldfs_pkg::CHAN_BLUE;
                    g_led_next  = g_led - 1'b1;
                  end else begin
                    g_chan_next = g_chan - 2'd1;
                  end
                end else begin
                  g_bit_next = g_bit - 1'b1;
                end
              end
            end else begin
              st.latch_pulse    = 1'b1;
              bit_position_next = '0;
              g_bit_next        = GBIT_RST;
              g_chan_next       = ldfs_pkg::CHAN_BLUE;
              g_led_next        = GLED_RST;
              dc_phase_next     = 3'd6;
              if (frame_kind && !pass_count) begin
                pass_count_next = 1'b1;
              end else begin
                pass_count_next = 1'b0;
                sending_next    = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
    st.busy = sending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending      <= 1'b0;
      frame_kind   <= 1'b0;
      pass_count   <= 1'b0;
      bit_position <= '0;
      g_bit        <= GBIT_RST;
      g_chan       <= ldfs_pkg::CHAN_BLUE;
      g_led        <= GLED_RST;
      dc_phase     <= 3'd6;
      row_valid    <= '0;
    end else if (fire) begin
      sending      <= sending_next;
      frame_kind   <= frame_kind_next;
      pass_count   <= pass_count_next;
      bit_position <= bit_position_next;
      g_bit        <= g_bit_next;
      g_chan       <= g_chan_next;
      g_led        <= g_led_next;
      dc_phase     <= dc_phase_next;
      if (ram.we) begin
        row_valid[ram.waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
    if (advance) begin
      s2 <= st;
    end
  end

endmodule

[src/led_driver_frame_serializer.sv]
// Serial frame generator for a 16-LED RGB PWM driver: one result item per input item,
// one item per clock cycle sustained when not stalled, via the input register, the
// grayscale store read stage and the result register. Every tick item reads at most one
// grayscale row through the single read port of the store RAM; set colour writes one
// row of three channels. The store reads as zero after reset through one valid bit per
// LED row, so no clearing pass runs and items are taken from the first cycle on.
// Depends on ldfs_pkg, ldfs_cfg, ldfs_ctrl, ldfs_ram and assert_macros.svh.
`include "assert_macros.svh"

module led_driver_frame_serializer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // led_index[3:0], red_level[19:4], green_level[35:20], blue_level[51:36]
  input  logic [55:0]                     s_axis_tdata,
  // command[1:0]
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // serial_data[0], shift_clock[1], latch_pulse[2], busy_res[3], rejected[4]
  output logic [7:0]                      m_axis_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ldfs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  ldfs_pkg::cfg_t     cfg;
  ldfs_pkg::in_item_t s_item;
  ldfs_pkg::stage_t   s2;
  ldfs_pkg::ram_req_t ram;
  logic               s2_valid;
  logic               en3;
  logic               advance;
  logic [ldfs_pkg::ROW_W-1:0]     rdata;
  logic [ldfs_pkg::ROW_IDX_W-1:0] bit_idx;
  logic               sd;
  logic [4:0]         res;
  logic               out_rej;
  logic               hold_rd;

  assign s_item.command     = ldfs_pkg::cmd_t'(s_axis_tuser);
  assign s_item.led_index   = s_axis_tdata[3:0];
  assign s_item.red_level   = s_axis_tdata[19:4];
  assign s_item.green_level = s_axis_tdata[35:20];
  assign s_item.blue_level  = s_axis_tdata[51:36];

  assign en3     = !m_axis_tvalid || m_axis_tready;
  assign advance = !s2_valid || en3;

  ldfs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ldfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_item   (s_item),
    .s_ready  (s_axis_tready),
    .cfg      (cfg),
    .advance  (advance),
    .s2_valid (s2_valid),
    .s2       (s2),
    .ram      (ram)
  );

  ldfs_ram #(
    .WIDTH (ldfs_pkg::ROW_W),
    .DEPTH (ldfs_pkg::NUM_LEDS)
  ) u_store (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (advance),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  assign bit_idx = ldfs_pkg::ROW_IDX_W'(s2.chan) * ldfs_pkg::ROW_IDX_W'(ldfs_pkg::GRAY_WIDTH)
                 + ldfs_pkg::ROW_IDX_W'(s2.bit_sel);
  assign sd = s2.use_ram ? (s2.row_valid && rdata[bit_idx]) : s2.sd_fixed;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en3) begin
      m_axis_tvalid <= s2_valid;
    end
    if (en3) begin
      m_axis_tdata <= {3'b000, s2.rejected, s2.busy, s2.latch_pulse, s2.shift_clock, sd};
    end
  end

  assign res     = m_axis_tdata[4:0];
  assign out_rej = m_axis_tvalid && res[4];
  assign hold_rd = s2_valid && !en3 && s2.use_ram && s2.row_valid;

  `ASSERT_IMPLIES(a_clk_latch, clk, rst, m_axis_tvalid, !(res[1] && res[2]), "clock with latch")
  `ASSERT_IMPLIES(a_reject_quiet, clk, rst, out_rej, res[3:1] == 3'b100, "reject moved frame")
  `ASSERT_NEXT(a_store_hold, clk, rst, hold_rd, $stable(rdata), "store data lost in stall")

endmodule
